[rtl/ghe_pkg.sv]
// ----------------------------------------------------------------------------
// ghe_pkg: geohash encoder shared types and constants
// Payload structs for the coordinate and hash channels, the base32
// alphabet and the constants of the divide-by-ten test.
// ----------------------------------------------------------------------------
`default_nettype none
package ghe_pkg;

	typedef struct packed {
		logic signed [30:0] latitude_e7;
		logic signed [31:0] longitude_e7;
	} coord_t;

	typedef struct packed {
		logic [6:0] hash_char;
		logic       invalid;
		logic       last;
	} hash_t;

	// Longest hash ever produced
	localparam logic [3:0] MAX_OUT = 4'd13;
	// Reset value of the character limit register
	localparam logic [5:0] MAX_CHARS_RST = 6'd63;

	// Inverse of 5 modulo 2^32 and the largest exact quotient by 5
	localparam logic [31:0] INV5     = 32'hCCCC_CCCD;
	localparam logic [31:0] MAX_Q5   = 32'h3333_3333;

	// Map a 5-bit code onto the geohash base32 alphabet
	function automatic logic [6:0] b32_char(input logic [4:0] code);
		logic [6:0] c;
		unique case (code)
			5'd0:  c = 7'h30; 5'd1:  c = 7'h31; 5'd2:  c = 7'h32; 5'd3:  c = 7'h33;
			5'd4:  c = 7'h34; 5'd5:  c = 7'h35; 5'd6:  c = 7'h36; 5'd7:  c = 7'h37;
			5'd8:  c = 7'h38; 5'd9:  c = 7'h39; 5'd10: c = 7'h62; 5'd11: c = 7'h63;
			5'd12: c = 7'h64; 5'd13: c = 7'h65; 5'd14: c = 7'h66; 5'd15: c = 7'h67;
			5'd16: c = 7'h68; 5'd17: c = 7'h6A; 5'd18: c = 7'h6B; 5'd19: c = 7'h6D;
			5'd20: c = 7'h6E; 5'd21: c = 7'h70; 5'd22: c = 7'h71; 5'd23: c = 7'h72;
			5'd24: c = 7'h73; 5'd25: c = 7'h74; 5'd26: c = 7'h75; 5'd27: c = 7'h76;
			5'd28: c = 7'h77; 5'd29: c = 7'h78; 5'd30: c = 7'h79; 5'd31: c = 7'h7A;
			default: c = 7'h30;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

[rtl/ghe_cell.sv]
// ----------------------------------------------------------------------------
// ghe_cell: one bisection cell
// Halves either the longitude or the latitude interval and passes both
// scaled remainders and the turn flag on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none
module ghe_cell #(
	parameter int RW = 40,
	parameter logic [RW-1:0] WL = '0,
	parameter logic [RW-1:0] WN = '0
) (
	input  wire logic [RW-1:0] rl_i,
	input  wire logic [RW-1:0] rn_i,
	input  wire logic          lon_turn_i,
	output logic      [RW-1:0] rl_o,
	output logic      [RW-1:0] rn_o,
	output logic               lon_turn_o,
	output logic               bit_o
);
	import ghe_pkg::*;

	logic [RW:0] t;

	// Double the selected remainder and fold it at the midpoint
	always_comb begin
		rl_o = rl_i;
		rn_o = rn_i;
		if (lon_turn_i) begin
			t = {rn_i, 1'b0};
			bit_o = t > {1'b0, WN};
			rn_o = bit_o ? RW'(t - {1'b0, WN}) : t[RW-1:0];
		end else begin
			t = {rl_i, 1'b0};
			bit_o = t > {1'b0, WL};
			rl_o = bit_o ? RW'(t - {1'b0, WL}) : t[RW-1:0];
		end
	end

	assign lon_turn_o = ~lon_turn_i;

endmodule
`default_nettype wire

[rtl/geohash_encoder_unit.sv]
// Flow: accept, then a trailing decimal zero scan for the precision,
// then one hash character per cycle while the output is not stalled
// (five bisections in a row of cells). One coordinate pair at a time.
// Out-of-range pairs finish with a single flagged beat.
// Reset (arst_n low) clears control state and sets max_chars to 63.
// ----------------------------------------------------------------------------
// geohash_encoder_unit: geohash base32 encoder
// Range check, trailing decimal zero scan for the precision, then bisection
// through a chain of five cells, one character per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module geohash_encoder_unit #(
	parameter int FRACTION_DIGITS = 7
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           coord_valid,
	output logic                coord_ready,
	input  wire ghe_pkg::coord_t coord,
	output logic                hash_valid,
	input  wire logic           hash_ready,
	output ghe_pkg::hash_t      hash,
	input  wire logic           cfg_we,
	input  wire logic [5:0]     cfg_data
);
	import ghe_pkg::*;

	localparam longint unsigned UNIT = 64'(10 ** FRACTION_DIGITS);
	localparam longint unsigned HL   = 90 * UNIT;
	localparam longint unsigned HN   = 180 * UNIT;
	localparam int RW = $clog2(2 * HN + 1);
	localparam int PW = RW + 3;
	localparam int KW = $clog2(FRACTION_DIGITS + 1);
	localparam logic [RW-1:0] WL_C = RW'(2 * HL);
	localparam logic [RW-1:0] WN_C = RW'(2 * HN);
	localparam logic [PW-1:0] HL_P = PW'(HL);
	localparam logic [PW-1:0] HN_P = PW'(HN);
	localparam logic signed [63:0] HL_S = 64'(HL);
	localparam logic signed [63:0] HN_S = 64'(HN);
	localparam logic [KW-1:0] K_END = KW'(FRACTION_DIGITS);

	typedef enum logic [1:0] {S_IDLE, S_PREP, S_ENC, S_INVAL} state_t;

	state_t         state_q;
	logic [5:0]     max_chars_q;
	logic [RW-1:0]  rl_q, rn_q, prec_q;
	logic [PW-1:0]  pl_q, pn_q;
	logic [31:0]    ml_q, mn_q;
	logic [KW-1:0]  k_q;
	logic [3:0]     cnt_q;
	logic           hash_valid_q;
	hash_t          hash_q;

	// Input decode
	logic signed [63:0] lat_w, lon_w, rl_sum, rn_sum;
	logic               out_range;
	logic [31:0]        lat_mag, lon_mag;

	always_comb begin
		lat_w = {{33{coord.latitude_e7[30]}}, coord.latitude_e7};
		lon_w = {{32{coord.longitude_e7[31]}}, coord.longitude_e7};
		out_range = (lat_w < -HL_S) || (lat_w > HL_S) || (lon_w < -HN_S) || (lon_w > HN_S);
		rl_sum = lat_w + HL_S;
		rn_sum = lon_w + HN_S;
		lat_mag = coord.latitude_e7[30] ? 32'(-lat_w) : lat_w[31:0];
		lon_mag = coord.longitude_e7[31] ? 32'(-lon_w) : lon_w[31:0];
	end

	// Divide-by-ten test on both magnitudes
	logic [31:0] pl5, pn5;
	logic        both_div;

	always_comb begin
		pl5 = ml_q * INV5;
		pn5 = mn_q * INV5;
		both_div = !ml_q[0] && (pl5 <= MAX_Q5) && !mn_q[0] && (pn5 <= MAX_Q5);
	end

	// Chain of bisection cells
	logic [RW-1:0] chl [6];
	logic [RW-1:0] chn [6];
	logic          cht [6];
	logic [4:0]    code;

	assign chl[0] = rl_q;
	assign chn[0] = rn_q;
	assign cht[0] = ~cnt_q[0];

	for (genvar g = 0; g < 5; g++) begin : g_cell
		ghe_cell #(.RW(RW), .WL(WL_C), .WN(WN_C)) u_cell (
			.rl_i(chl[g]), .rn_i(chn[g]), .lon_turn_i(cht[g]),
			.rl_o(chl[g+1]), .rn_o(chn[g+1]), .lon_turn_o(cht[g+1]),
			.bit_o(code[4-g])
		);
	end

	// Precision tracking and stop decision
	logic [3:0]    limit;
	logic [PW-1:0] pl_nx, pn_nx;
	logic          stop_now, last_nx, slot_free, emit;

	always_comb begin
		limit = (max_chars_q < 6'(MAX_OUT)) ? max_chars_q[3:0] : MAX_OUT;
		if (pl_q > HL_P) pl_nx = pl_q;
		else pl_nx = cnt_q[0] ? (pl_q << 3) : (pl_q << 2);
		if (pn_q > HN_P) pn_nx = pn_q;
		else pn_nx = cnt_q[0] ? (pn_q << 2) : (pn_q << 3);
		stop_now = (cnt_q == limit) || ((pl_q > HL_P) && (pn_q > HN_P));
		last_nx = (cnt_q + 4'd1 == limit) || ((pl_nx > HL_P) && (pn_nx > HN_P));
		slot_free = !hash_valid_q || hash_ready;
		emit = slot_free && (((state_q == S_ENC) && !stop_now) || (state_q == S_INVAL));
	end

	assign coord_ready = (state_q == S_IDLE);
	assign hash_valid  = hash_valid_q;
	assign hash        = hash_q;

	// Hold the character limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chars_q <= MAX_CHARS_RST;
		end else if (cfg_we) begin
			max_chars_q <= cfg_data;
		end
	end

	// Sequence one coordinate pair and drive the output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hash_valid_q <= 1'b0;
		end else begin
			if (emit) hash_valid_q <= 1'b1;
			else if (hash_ready) hash_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (coord_valid) begin
						state_q <= out_range ? S_INVAL : S_PREP;
					end
				end
				S_PREP: begin
					if (!(both_div && k_q < K_END)) state_q <= S_ENC;
				end
				S_ENC: begin
					if (slot_free) begin
						if (stop_now || last_nx) state_q <= S_IDLE;
					end
				end
				S_INVAL: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Advance the datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				rl_q <= rl_sum[RW-1:0];
				rn_q <= rn_sum[RW-1:0];
				ml_q <= lat_mag;
				mn_q <= lon_mag;
				prec_q <= RW'(1);
				k_q <= '0;
				cnt_q <= '0;
			end
			S_PREP: begin
				if (both_div && k_q < K_END) begin
					ml_q <= {1'b0, pl5[31:1]};
					mn_q <= {1'b0, pn5[31:1]};
					prec_q <= RW'({prec_q, 3'b000} + {prec_q, 1'b0});
					k_q <= k_q + KW'(1);
				end else begin
					pl_q <= PW'(prec_q);
					pn_q <= PW'(prec_q);
				end
			end
			S_ENC: begin
				if (slot_free && !stop_now) begin
					rl_q <= chl[5];
					rn_q <= chn[5];
					pl_q <= pl_nx;
					pn_q <= pn_nx;
					cnt_q <= cnt_q + 4'd1;
					hash_q.hash_char <= b32_char(code);
					hash_q.invalid <= 1'b0;
					hash_q.last <= last_nx;
				end
			end
			S_INVAL: begin
				if (slot_free) begin
					hash_q.hash_char <= '0;
					hash_q.invalid <= 1'b1;
					hash_q.last <= 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

[rtl/ghe_checker.sv]
// ----------------------------------------------------------------------------
// ghe_checker: port-level checks for the geohash encoder
// Watches both channels of the top level and flags protocol or framing slips.
// ----------------------------------------------------------------------------
`default_nettype none
module ghe_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            coord_valid,
	input wire logic            coord_ready,
	input wire ghe_pkg::coord_t coord,
	input wire logic            hash_valid,
	input wire logic            hash_ready,
	input wire ghe_pkg::hash_t  hash,
	input wire logic            cfg_we,
	input wire logic [5:0]      cfg_data
);
	import ghe_pkg::*;

	// Stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hash_valid && !hash_ready |=> hash_valid && $stable(hash))
		else $error("hash beat changed while stalled");

	// Flagged beat ends its item and carries no character
	a_inval: assert property (@(posedge clk) disable iff (!arst_n)
		hash_valid && hash.invalid |-> hash.last && hash.hash_char == 7'd0)
		else $error("invalid beat not final or carries a character");

	// Valid beats carry a character within the range of the base32 alphabet
	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		hash_valid && !hash.invalid |-> hash.hash_char >= 7'h30 && hash.hash_char <= 7'h7A)
		else $error("hash character out of alphabet");

	// One pair at a time: busy right after a coordinate beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		coord_valid && coord_ready |=> !coord_ready)
		else $error("coordinate taken while busy");

endmodule

bind geohash_encoder_unit ghe_checker u_ghe_checker (.*);
`default_nettype wire
